>>> hw/rtl/vt4_pkg.sv
// Shared types and constants for the 4x4 vertex transform pipeline.
// No dependencies; imported by every module of the block.
package vt4_pkg;

    localparam int unsigned DIM        = 4;
    localparam int unsigned COEF_W     = 32;
    localparam int unsigned PROD_W     = 2 * COEF_W;
    localparam int unsigned PAIR_W     = PROD_W + 1;
    localparam int unsigned SUM_W      = PROD_W + 2;
    localparam int unsigned NUM_REGS   = 8;
    localparam int unsigned REG_W      = 64;
    localparam int unsigned REG_IDX_W  = $clog2(NUM_REGS);
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned FRAC_BITS_DEFAULT = 16;

    // Vector of four Q16.16 components, component 0 in the lowest bits
    typedef logic [DIM-1:0][COEF_W-1:0] vec_t;
    // Coefficient matrix, indexed [k][r]
    typedef logic [DIM-1:0][DIM-1:0][COEF_W-1:0] coef_mat_t;
    // Full-precision products, indexed [k][r]
    typedef logic [DIM-1:0][DIM-1:0][PROD_W-1:0] prod_mat_t;
    // Partial sums: [r][0] = rows 0+1, [r][1] = rows 2+3
    typedef logic [DIM-1:0][1:0][PAIR_W-1:0] pair_mat_t;
    // Complete column sums
    typedef logic [DIM-1:0][SUM_W-1:0] sum_vec_t;
    typedef logic [NUM_REGS-1:0][REG_W-1:0] reg_file_t;

    // Reset contents: identity matrix
    localparam reg_file_t COEF_RESET = '{
        64'h0001_0000_0000_0000,   // coef_k3_r23
        64'h0000_0000_0000_0000,   // coef_k3_r01
        64'h0000_0000_0001_0000,   // coef_k2_r23
        64'h0000_0000_0000_0000,   // coef_k2_r01
        64'h0000_0000_0000_0000,   // coef_k1_r23
        64'h0001_0000_0000_0000,   // coef_k1_r01
        64'h0000_0000_0000_0000,   // coef_k0_r23
        64'h0000_0000_0001_0000    // coef_k0_r01
    };

endpackage

>>> hw/rtl/vt4_coef_regs.sv
// Coefficient register file: eight 64-bit registers, two Q16.16 entries each.
// Depends on vt4_pkg.
module vt4_coef_regs import vt4_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    output coef_mat_t            coef
);

    reg_file_t regs_reg;
    reg_file_t regs_next;

    // Write the addressed register; drop writes beyond the list
    always_comb begin
        regs_next = regs_reg;
        if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
            regs_next[cfg_index[REG_IDX_W-1:0]] = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg <= COEF_RESET;
        end else begin
            regs_reg <= regs_next;
        end
    end

    // Unpack m[k][r]: register 2k+r[1], half r[0]
    always_comb begin
        for (int k = 0; k < DIM; k++) begin
            for (int r = 0; r < DIM; r++) begin
                coef[k][r] = (r % 2 == 1) ? regs_reg[2*k + r/2][REG_W-1:COEF_W]
                                          : regs_reg[2*k + r/2][COEF_W-1:0];
            end
        end
    end

endmodule

>>> hw/rtl/vt4_mult.sv
// Product stage: sixteen 32x32 signed multipliers, registered.
// Depends on vt4_pkg.
module vt4_mult import vt4_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  vec_t      in_vec,
    input  coef_mat_t coef,
    output logic      out_valid,
    input  logic      out_ready,
    output prod_mat_t out_prod
);

    logic      vld_reg;
    logic      vld_next;
    prod_mat_t prod_reg;
    prod_mat_t prod_next;
    logic      advance;

    // Advance when the stage is empty or its content is taken
    assign advance  = !vld_reg || out_ready;
    assign in_ready = advance;
    assign vld_next = advance ? in_valid : vld_reg;

    always_comb begin
        for (int k = 0; k < DIM; k++) begin
            for (int r = 0; r < DIM; r++) begin
                prod_next[k][r] = PROD_W'($signed(coef[k][r]) * $signed(in_vec[k]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Hold payload unless a new transaction enters
    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_prod  = prod_reg;

endmodule

>>> hw/rtl/vt4_adder.sv
// Two-level registered adder tree summing four products per column.
// Depends on vt4_pkg.
module vt4_adder import vt4_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  prod_mat_t in_prod,
    output logic      out_valid,
    input  logic      out_ready,
    output sum_vec_t  out_sum
);

    logic      pair_vld_reg;
    logic      pair_vld_next;
    pair_mat_t pair_reg;
    pair_mat_t pair_next;
    logic      sum_vld_reg;
    logic      sum_vld_next;
    sum_vec_t  sum_reg;
    sum_vec_t  sum_next;
    logic      sum_adv;
    logic      pair_adv;

    // Stall chain: a stage moves when empty or when the next one moves
    assign sum_adv       = !sum_vld_reg || out_ready;
    assign pair_adv      = !pair_vld_reg || sum_adv;
    assign in_ready      = pair_adv;
    assign pair_vld_next = pair_adv ? in_valid : pair_vld_reg;
    assign sum_vld_next  = sum_adv ? pair_vld_reg : sum_vld_reg;

    // First level: rows 0+1 and rows 2+3 of each column
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            pair_next[r][0] = PAIR_W'($signed(in_prod[0][r])) +
                              PAIR_W'($signed(in_prod[1][r]));
            pair_next[r][1] = PAIR_W'($signed(in_prod[2][r])) +
                              PAIR_W'($signed(in_prod[3][r]));
        end
    end

    // Second level: complete column sum
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            sum_next[r] = SUM_W'($signed(pair_reg[r][0])) +
                          SUM_W'($signed(pair_reg[r][1]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_vld_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
        end else begin
            pair_vld_reg <= pair_vld_next;
            sum_vld_reg  <= sum_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pair_adv && in_valid) begin
            pair_reg <= pair_next;
        end
        if (sum_adv && pair_vld_reg) begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = sum_vld_reg;
    assign out_sum   = sum_reg;

endmodule

>>> hw/rtl/vt4_sat.sv
// Output stage: arithmetic shift by the fraction width, clamp, output register.
// Depends on vt4_pkg.
module vt4_sat import vt4_pkg::*; #(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  sum_vec_t in_sum,
    output logic     out_valid,
    input  logic     out_ready,
    output vec_t     out_vec,
    output logic     out_sat
);

    localparam logic [COEF_W-1:0] MAX_VAL = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] MIN_VAL = {1'b1, {(COEF_W-1){1'b0}}};

    logic             vld_reg;
    logic             vld_next;
    vec_t             vec_reg;
    vec_t             vec_next;
    logic             sat_reg;
    logic             sat_next;
    logic             advance;
    logic [SUM_W-1:0] shifted;

    assign advance  = !vld_reg || out_ready;
    assign in_ready = advance;
    assign vld_next = advance ? in_valid : vld_reg;

    // Shift toward minus infinity, then clamp when the upper bits are not a sign run
    always_comb begin
        sat_next = 1'b0;
        shifted  = '0;
        for (int r = 0; r < DIM; r++) begin
            shifted = SUM_W'($signed(in_sum[r]) >>> FRAC_BITS);
            if (shifted[SUM_W-1] && !(&shifted[SUM_W-1:COEF_W-1])) begin
                vec_next[r] = MIN_VAL;
                sat_next    = 1'b1;
            end else if (!shifted[SUM_W-1] && (|shifted[SUM_W-1:COEF_W-1])) begin
                vec_next[r] = MAX_VAL;
                sat_next    = 1'b1;
            end else begin
                vec_next[r] = shifted[COEF_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            vec_reg <= vec_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_vec   = vec_reg;
    assign out_sat   = sat_reg;

endmodule

>>> hw/rtl/vertex_transform_4x4_core.sv
// Vertex transform: 4x4 Q16.16 matrix times a stream of 4-component vectors.
// The multiply, two adder levels and shift/clamp are each registered, in that
// order; throughput one vector per cycle with elastic stalls.
// Reset (aresetn low, synchronous) empties the pipeline and loads the identity.
// Depends on vt4_pkg, vt4_coef_regs, vt4_mult, vt4_adder, vt4_sat.
module vertex_transform_4x4_core import vt4_pkg::*; #(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [DIM*COEF_W-1:0]  s_axis_tdata,  // in_x, in_y, in_z, in_w
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [DIM*COEF_W-1:0]  m_axis_tdata,  // out_x, out_y, out_z, out_w
    output logic                   m_axis_tuser,  // saturated
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [REG_W-1:0]       cfg_data
);

    coef_mat_t coef;
    prod_mat_t prod;
    sum_vec_t  sum;
    vec_t      res_vec;
    logic      mul_vld;
    logic      mul_rdy;
    logic      add_vld;
    logic      add_rdy;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    vt4_coef_regs u_coef (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    vt4_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_vec    (vec_t'(s_axis_tdata)),
        .coef      (coef),
        .out_valid (mul_vld),
        .out_ready (mul_rdy),
        .out_prod  (prod)
    );

    vt4_adder u_adder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_vld),
        .in_ready  (mul_rdy),
        .in_prod   (prod),
        .out_valid (add_vld),
        .out_ready (add_rdy),
        .out_sum   (sum)
    );

    vt4_sat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (add_vld),
        .in_ready  (add_rdy),
        .in_sum    (sum),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_vec   (res_vec),
        .out_sat   (m_axis_tuser)
    );

    assign m_axis_tdata = res_vec;

endmodule

>>> hw/rtl/vt4_checker.sv
// Port-level checks for the vertex transform core, bound to the top level.
// Depends on vt4_pkg and vertex_transform_4x4_core.
module vt4_checker import vt4_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [DIM*COEF_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its data and flag
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // The flag is only raised when some component sits at a clamp value
    a_sat_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[31:0]   == 32'h7FFF_FFFF || m_axis_tdata[31:0]   == 32'h8000_0000 ||
            m_axis_tdata[63:32]  == 32'h7FFF_FFFF || m_axis_tdata[63:32]  == 32'h8000_0000 ||
            m_axis_tdata[95:64]  == 32'h7FFF_FFFF || m_axis_tdata[95:64]  == 32'h8000_0000 ||
            m_axis_tdata[127:96] == 32'h7FFF_FFFF || m_axis_tdata[127:96] == 32'h8000_0000)
        else $error("saturation flag without clamped component");

    // With the output free, the pipeline must take a new transaction
    a_no_bubble_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is free");

endmodule

bind vertex_transform_4x4_core vt4_checker u_vt4_checker (.*);

>>> test/vt4_result_checker.sv
`timescale 1ns / 100ps
// Result checker for vertex_transform_4x4_core: follows coefficient writes, predicts each
// transformed vertex and compares it with the result stream. Depends on vt4_pkg only.
module vt4_result_checker import vt4_pkg::*; #(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [DIM*COEF_W-1:0] s_axis_tdata,   // in_x, in_y, in_z, in_w
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [DIM*COEF_W-1:0] m_axis_tdata,   // out_x, out_y, out_z, out_w
    input  logic                  m_axis_tuser,   // saturated
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [REG_W-1:0]      cfg_data,
    output int                    mismatch_count,
    output int                    pending_count
);

    // Accumulator wide enough for four full 32x32 signed products
    localparam int ACC_W        = SUM_W + 2;
    localparam logic signed [ACC_W-1:0] CLAMP_HI = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0] CLAMP_LO = -64'sd2147483648;
    localparam logic [COEF_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic sat;
        vec_t comps;
    } vertex_result_t;

    reg_file_t      coef_regs;
    vertex_result_t expected_vertices[$];

    function automatic string comp_name(input int r);
        case (r)
            0:       return "out_x";
            1:       return "out_y";
            2:       return "out_z";
            default: return "out_w";
        endcase
    endfunction

    // Column r of the matrix dotted with the vector, floor shift, clamp per component
    function automatic vertex_result_t transform_vertex(input vec_t v, input reg_file_t regs);
        vertex_result_t           res;
        logic [REG_W-1:0]         word;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] x;
        logic signed [PROD_W-1:0] prod;
        logic signed [ACC_W-1:0]  acc;
        logic signed [ACC_W-1:0]  scaled;
        res.sat = 1'b0;
        for (int r = 0; r < DIM; r++) begin
            acc = '0;
            for (int k = 0; k < DIM; k++) begin
                word = regs[(k << 1) | (r >> 1)];
                c    = (r & 1) ? word[REG_W-1:COEF_W] : word[COEF_W-1:0];
                x    = v[k];
                prod = c * x;
                acc  = acc + prod;
            end
            scaled = acc >>> FRAC_BITS;
            if (scaled > CLAMP_HI) begin
                res.comps[r] = SAT_POS;
                res.sat      = 1'b1;
            end else if (scaled < CLAMP_LO) begin
                res.comps[r] = SAT_NEG;
                res.sat      = 1'b1;
            end else begin
                res.comps[r] = scaled[COEF_W-1:0];
            end
        end
        return res;
    endfunction

    // Report and count every mismatch
    task automatic report_mismatch(input string field, input logic [COEF_W-1:0] want,
                                   input logic [COEF_W-1:0] got);
        $error("%s mismatch: expected %h, actual %h", field, want, got);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        vertex_result_t want;
        vec_t           got;
        if (!aresetn) begin
            coef_regs = COEF_RESET;
            expected_vertices.delete();
            mismatch_count = 0;
            pending_count  = 0;
        end else begin
            // Predict each accepted vertex with the matrix in force before this edge
            if (s_axis_tvalid && s_axis_tready)
                expected_vertices.push_back(transform_vertex(s_axis_tdata, coef_regs));

            // Follow register writes; indexes past the file are dropped
            if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
                coef_regs[cfg_index[REG_IDX_W-1:0]] = cfg_data;

            // Compare each result transaction with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (expected_vertices.size() == 0) begin
                    $error("result transaction with no vertex pending: data %h", got);
                    mismatch_count++;
                end else begin
                    want = expected_vertices.pop_front();
                    for (int r = 0; r < DIM; r++)
                        if (got[r] !== want.comps[r])
                            report_mismatch(comp_name(r), want.comps[r], got[r]);
                    if (m_axis_tuser !== want.sat)
                        report_mismatch("saturated", COEF_W'(want.sat),
                                        COEF_W'(m_axis_tuser));
                end
            end
            pending_count = expected_vertices.size();
        end
    end

endmodule

>>> test/tb_vertex_transform_4x4_core.sv
`timescale 1ns / 100ps
// Testbench top for vertex_transform_4x4_core: clock, reset, stimulus and verdict.
// Depends on vt4_pkg, the core RTL and vt4_result_checker.
module tb_vertex_transform_4x4_core;
    import vt4_pkg::*;

    localparam int unsigned FRAC_BITS     = 16;
    localparam int          PIPE_LATENCY  = 4;
    localparam int          SETTLE_CYCLES = PIPE_LATENCY + 6;
    localparam int          LONG_HOLD     = 120;
    localparam int          NUM_SETS      = 5;
    localparam int          ITEMS_PER_SET = 90;
    localparam int          CYCLE_LIMIT   = 300000;

    localparam logic [COEF_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] Q_MIN     = 32'h8000_0000;
    localparam logic [COEF_W-1:0] Q_ONE     = 32'h0001_0000;
    localparam logic [COEF_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;
    localparam logic [COEF_W-1:0] Q_LSB     = 32'h0000_0001;
    localparam logic [COEF_W-1:0] Q_LSB_NEG = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_K0_R01, COEF_K0_R23, COEF_K1_R01, COEF_K1_R23,
        COEF_K2_R01, COEF_K2_R23, COEF_K3_R01, COEF_K3_R23
    } coef_reg_e;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST_UNUSED = CFG_IDX_W'(NUM_REGS);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST         = '1;

    typedef enum int { SPREAD_FULL, SPREAD_MODERATE, SPREAD_EXTREME } spread_e;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DIM*COEF_W-1:0] s_axis_tdata;   // in_x, in_y, in_z, in_w
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DIM*COEF_W-1:0] m_axis_tdata;   // out_x, out_y, out_z, out_w
    logic                  m_axis_tuser;   // saturated
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [REG_W-1:0]      cfg_data;

    int   mismatch_count;
    int   pending_count;
    int   burst_left;
    int   cycle_count;
    int   long_hold_reqs;

    vertex_transform_4x4_core #(.FRAC_BITS(FRAC_BITS)) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    vt4_result_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // 12 ns clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: end the run if the block hangs
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Result side: stall in random modes, honor a long hold-off when asked
    initial begin
        int hold_left;
        int span_left;
        int mode;
        int holds_served;
        m_axis_tready = 1'b0;
        hold_left     = 0;
        span_left     = 0;
        mode          = 0;
        holds_served  = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else if (long_hold_reqs > holds_served) begin
                holds_served++;
                hold_left     = LONG_HOLD - 1;
                m_axis_tready = 1'b0;
            end else begin
                if (span_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    span_left = $urandom_range(8, 64);
                end
                span_left--;
                case (mode)
                    0:       m_axis_tready = 1'b1;
                    1:       m_axis_tready = 1'($urandom_range(0, 1));
                    default: m_axis_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic vec_t make_vec(input logic [COEF_W-1:0] x, input logic [COEF_W-1:0] y,
                                      input logic [COEF_W-1:0] z, input logic [COEF_W-1:0] w);
        return {w, z, y, x};
    endfunction

    function automatic logic [COEF_W-1:0] random_coef(input spread_e spread);
        logic [COEF_W-1:0] c;
        case (spread)
            SPREAD_FULL:     c = $urandom;
            SPREAD_MODERATE: c = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: begin
                case ($urandom_range(0, 5))
                    0:       c = Q_MAX;
                    1:       c = Q_MIN;
                    2:       c = '0;
                    3:       c = Q_LSB_NEG;
                    4:       c = Q_NEG_ONE;
                    default: c = Q_ONE;
                endcase
            end
        endcase
        return c;
    endfunction

    // Mostly full-range and mid-range components, some extremes
    function automatic vec_t random_vec();
        vec_t v;
        for (int k = 0; k < DIM; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: v[k] = random_coef(SPREAD_FULL);
                4, 5, 6, 7: v[k] = random_coef(SPREAD_MODERATE);
                default:    v[k] = random_coef(SPREAD_EXTREME);
            endcase
        end
        return v;
    endfunction

    // Place m[k][r] into the register layout: two coefficients per register
    function automatic reg_file_t pack_matrix(input coef_mat_t m);
        reg_file_t regs;
        for (int k = 0; k < DIM; k++)
            for (int r = 0; r < DIM; r++)
                regs[k * 2 + r / 2][(r % 2) * COEF_W +: COEF_W] = m[k][r];
        return regs;
    endfunction

    function automatic reg_file_t uniform_matrix(input logic [COEF_W-1:0] c);
        coef_mat_t m;
        for (int k = 0; k < DIM; k++)
            for (int r = 0; r < DIM; r++)
                m[k][r] = c;
        return pack_matrix(m);
    endfunction

    function automatic reg_file_t random_matrix(input spread_e dominant);
        coef_mat_t m;
        for (int k = 0; k < DIM; k++)
            for (int r = 0; r < DIM; r++)
                m[k][r] = ($urandom_range(0, 3) == 0) ?
                          random_coef(spread_e'($urandom_range(0, 2))) : random_coef(dominant);
        return pack_matrix(m);
    endfunction

    function automatic reg_file_t random_words();
        reg_file_t regs;
        for (int i = 0; i < NUM_REGS; i++)
            regs[i] = {$urandom, $urandom};
        return regs;
    endfunction

    // Offer one vertex; open a new burst, mostly after a random gap, when the last one ran out
    task automatic push_vertex(input vec_t v);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = v;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        burst_left--;
        @(negedge aclk);
    endtask

    // Stop offering, wait for every predicted result, then let the pipeline settle
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_matrix(input reg_file_t regs);
        drain();
        for (int i = 0; i < NUM_REGS; i++)
            write_coef(coef_reg_e'(i), regs[i]);
    endtask

    // Stimulus and verdict
    initial begin
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        long_hold_reqs = 0;
        burst_left     = 0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Identity after reset: vectors pass through unchanged
        push_vertex(make_vec('0, '0, '0, '0));
        push_vertex(make_vec(Q_ONE, Q_NEG_ONE, Q_MAX, Q_MIN));
        push_vertex(make_vec(Q_MIN, Q_MAX, Q_LSB_NEG, Q_LSB));
        push_vertex(make_vec(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555));

        // Writes past the register file must leave the identity in place
        drain();
        write_coef(CFG_IDX_FIRST_UNUSED, '1);
        write_coef(CFG_IDX_LAST, {$urandom, $urandom});
        push_vertex(make_vec(Q_MAX, Q_LSB, Q_MIN, Q_NEG_ONE));
        push_vertex(make_vec(32'h1234_5678, 32'h9ABC_DEF0, Q_ONE, '0));

        // Largest positive coefficients: saturate high and low, and a cancelling mix
        load_matrix(uniform_matrix(Q_MAX));
        push_vertex(make_vec(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        push_vertex(make_vec(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        push_vertex(make_vec(Q_MAX, Q_MIN, Q_MAX, Q_MIN));

        // Most negative coefficients: saturate low and high
        load_matrix(uniform_matrix(Q_MIN));
        push_vertex(make_vec(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        push_vertex(make_vec(Q_MIN, Q_MIN, Q_MIN, Q_MIN));

        // Tiny negative coefficients: the shift rounds toward minus infinity
        load_matrix(uniform_matrix(Q_LSB_NEG));
        push_vertex(make_vec(Q_LSB, '0, '0, '0));
        push_vertex(make_vec(Q_LSB, Q_LSB, Q_LSB, '0));
        push_vertex(make_vec(Q_ONE, Q_ONE, '0, '0));

        // Saturate one column only, after rewriting a single register
        drain();
        write_coef(COEF_K0_R01, {Q_ONE, Q_MAX});
        push_vertex(make_vec(Q_MAX, '0, '0, '0));
        push_vertex(make_vec(Q_MIN, '0, '0, '0));

        // Random vertices under several matrices; long hold-off in some sets
        for (int cfg_set = 0; cfg_set < NUM_SETS; cfg_set++) begin
            case (cfg_set)
                0:       load_matrix(random_matrix(SPREAD_FULL));
                1:       load_matrix(random_matrix(SPREAD_MODERATE));
                2:       load_matrix(random_words());
                3:       load_matrix(random_matrix(SPREAD_EXTREME));
                default: load_matrix(random_matrix(SPREAD_MODERATE));
            endcase
            write_coef(CFG_IDX_W'($urandom_range(NUM_REGS, 2 ** CFG_IDX_W - 1)),
                       {$urandom, $urandom});
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                if (n == ITEMS_PER_SET / 3 && cfg_set % 2 == 0)
                    long_hold_reqs++;
                push_vertex(random_vec());
            end
        end

        drain();
        if (mismatch_count == 0 && pending_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
